### rtl/arx_byte_shuffle_permutation_defines.svh
// Assertion macros for the checker of the byte-shuffle permutation block.
`ifndef ARX_BYTE_SHUFFLE_PERMUTATION_DEFINES_SVH
`define ARX_BYTE_SHUFFLE_PERMUTATION_DEFINES_SVH

// Clocked assertion, switched off while reset is asserted.
`define ARXBSP_ASSERT(lbl, clk, rstn, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Clocked assertion that is also checked during reset.
`define ARXBSP_ASSERT_ALWAYS(lbl, clk, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

### rtl/arxbsp_pkg.sv
// Types, shuffle tables and round functions of the byte-shuffle permutation.
`default_nettype none

package arxbsp_pkg;

	localparam int NUM_ROUNDS_DEF = 16;
	localparam int NUM_ROUNDS_MAX = 32;

	localparam int SHUF_A [16] = '{0, 5, 10, 15, 4, 9, 14, 3, 8, 13, 2, 7, 12, 1, 6, 11};
	localparam int SHUF_B [16] = '{1, 2, 3, 0, 6, 7, 4, 5, 10, 11, 8, 9, 15, 12, 13, 14};
	localparam int SHUF_C [16] = '{2, 3, 0, 1, 6, 7, 4, 5, 10, 11, 8, 9, 14, 15, 12, 13};
	localparam int SHUF_D [16] = '{3, 0, 1, 2, 7, 4, 5, 6, 11, 8, 9, 10, 15, 12, 13, 14};

	typedef struct packed {
		logic [63:0] a_low;
		logic [63:0] a_high;
		logic [63:0] b_low;
		logic [63:0] b_high;
		logic [63:0] c_low;
		logic [63:0] c_high;
		logic [63:0] d_low;
		logic [63:0] d_high;
	} blk_t;

	typedef struct packed {
		logic [63:0] out_a_low;
		logic [63:0] out_a_high;
		logic [63:0] out_b_low;
		logic [63:0] out_b_high;
		logic [63:0] out_c_low;
		logic [63:0] out_c_high;
		logic [63:0] out_d_low;
		logic [63:0] out_d_high;
	} res_t;

	// Working state, each word with the high half in bits 127:64.
	typedef struct packed {
		logic [127:0] a;
		logic [127:0] b;
		logic [127:0] c;
		logic [127:0] d;
	} state_t;

	typedef struct packed {
		logic en;
		logic valid;
	} stg_ctl_t;

	// Result byte i takes source byte lst[15-i].
	function automatic logic [127:0] byte_perm(input logic [127:0] w, input int lst [16]);
		logic [127:0] r;
		r = '0;
		for (int i = 0; i < 16; i++) begin
			r[8*i +: 8] = w[8*lst[15-i] +: 8];
		end
		return r;
	endfunction

	function automatic state_t mix_step(input state_t s);
		state_t t;
		t = s;
		t.a = t.a ^ t.b;
		t.c = t.c ^ t.d;
		t.b = t.b ^ t.c;
		t.d = t.d ^ t.a ^ t.b;
		// add per 64-bit half, carries stay inside each half
		t.a[63:0]   = t.a[63:0] + t.b[63:0];
		t.a[127:64] = t.a[127:64] + t.b[127:64];
		return t;
	endfunction

endpackage

`default_nettype wire

### rtl/arxbsp_stream_if.sv
// Valid/ready stream channel carrying one payload of type T.
`default_nettype none

interface arxbsp_stream_if #(
	parameter type T = logic
) ();
	logic valid;
	logic ready;
	T     data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

### rtl/arx_byte_shuffle_permutation.sv
// Top level of the 512-bit ARX byte-shuffle permutation pipeline.
// Usage:
//   block  - sink channel, one 512-bit state per transaction as eight 64-bit
//            fields (a_low .. d_high).
//   result - source channel, the permuted state (out_a_low .. out_d_high).
// The rounds are fully unrolled: every round is two register stages, each
// holding one mix step with its 64-bit adds and the byte permutes that
// follow it. Throughput is one transaction per cycle while the receiver
// does not stall; the mix step's 64-bit add sets the stage depth.
// Reset clears every stage valid bit; no result is shown after reset until
// a new block has gone through the whole pipeline.
// When the receiver stalls with a result waiting, the whole pipeline holds
// and block.ready drops; block.ready stays high while the output register
// is empty or being taken, so a new block enters every cycle then.
`default_nettype none

module arx_byte_shuffle_permutation #(
	parameter int NUM_ROUNDS = arxbsp_pkg::NUM_ROUNDS_DEF
) (
	input wire logic          clk,
	input wire logic          arst_n,
	arxbsp_stream_if.sink     block,
	arxbsp_stream_if.source   result
);
	import arxbsp_pkg::*;

	localparam int DEPTH = 2 * NUM_ROUNDS;

	logic   adv;
	logic   valid_pipe [DEPTH+1];
	state_t state_pipe [DEPTH+1];

	// advance everything unless a finished result is waiting
	assign adv         = !result.valid || result.ready;
	assign block.ready = adv;

	assign valid_pipe[0]   = block.valid;
	assign state_pipe[0].a = {block.data.a_high, block.data.a_low};
	assign state_pipe[0].b = {block.data.b_high, block.data.b_low};
	assign state_pipe[0].c = {block.data.c_high, block.data.c_low};
	assign state_pipe[0].d = {block.data.d_high, block.data.d_low};

	for (genvar s = 0; s < DEPTH; s++) begin : g_stage
		stg_ctl_t ctl;
		assign ctl.en    = adv;
		assign ctl.valid = valid_pipe[s];

		arxbsp_stage #(
			.ROUND (s / 2),
			.PHASE (1'(s % 2))
		) u_stage (
			.clk       (clk),
			.arst_n    (arst_n),
			.ctl       (ctl),
			.state_in  (state_pipe[s]),
			.valid_out (valid_pipe[s+1]),
			.state_out (state_pipe[s+1])
		);
	end

	assign result.valid           = valid_pipe[DEPTH];
	assign result.data.out_a_low  = state_pipe[DEPTH].a[63:0];
	assign result.data.out_a_high = state_pipe[DEPTH].a[127:64];
	assign result.data.out_b_low  = state_pipe[DEPTH].b[63:0];
	assign result.data.out_b_high = state_pipe[DEPTH].b[127:64];
	assign result.data.out_c_low  = state_pipe[DEPTH].c[63:0];
	assign result.data.out_c_high = state_pipe[DEPTH].c[127:64];
	assign result.data.out_d_low  = state_pipe[DEPTH].d[63:0];
	assign result.data.out_d_high = state_pipe[DEPTH].d[127:64];

endmodule

`default_nettype wire

### rtl/arxbsp_stage.sv
// One half-round pipeline stage: round constant (first half only), mix step plus byte permutes, then a register.
`default_nettype none

module arxbsp_stage #(
	parameter int ROUND = 0,
	parameter bit PHASE = 1'b0
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire arxbsp_pkg::stg_ctl_t ctl,
	input  wire arxbsp_pkg::state_t   state_in,
	output logic                   valid_out,
	output arxbsp_pkg::state_t     state_out
);
	import arxbsp_pkg::*;

	// Round constant is 1<<r in each 64-bit half, zero from round 32 on.
	localparam logic [63:0] RC = (ROUND < NUM_ROUNDS_MAX) ? (64'd1 << ROUND) : 64'd0;

	state_t nxt;
	state_t pre;

	// this stage's registers
	logic   valid_s1;
	state_t state_s1;

	always_comb begin
		pre = state_in;
		if (PHASE == 1'b0) begin
			pre.a = state_in.a ^ {RC, RC};
		end
		nxt = mix_step(pre);
		if (PHASE == 1'b0) begin
			nxt.a = byte_perm(nxt.a, SHUF_A);
		end else begin
			nxt.b = byte_perm(nxt.b, SHUF_B);
			nxt.c = byte_perm(nxt.c, SHUF_C);
			nxt.d = byte_perm(nxt.d, SHUF_D);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (ctl.en) begin
			valid_s1 <= ctl.valid;
		end
	end

	// load only real transactions, bubbles leave the data alone
	always_ff @(posedge clk) begin
		if (ctl.en && ctl.valid) begin
			state_s1 <= nxt;
		end
	end

	assign valid_out = valid_s1;
	assign state_out = state_s1;

endmodule

`default_nettype wire

### rtl/arxbsp_checker.sv
// Port-level checker for the byte-shuffle permutation block, with its bind.
`default_nettype none
`include "arx_byte_shuffle_permutation_defines.svh"

module arxbsp_checker (
	input wire logic             clk,
	input wire logic             arst_n,
	input wire logic             in_ready,
	input wire logic             out_valid,
	input wire logic             out_ready,
	input wire arxbsp_pkg::res_t out_data
);
	import arxbsp_pkg::*;

	logic out_stall;
	assign out_stall = out_valid && !out_ready;

	// a waiting result stays until taken
	`ARXBSP_ASSERT(a_res_hold, clk, arst_n, out_stall |=> out_valid, "result dropped while stalled")
	`ARXBSP_ASSERT(a_res_stable, clk, arst_n, out_stall |=> $stable(out_data), "stalled result changed")
	// input side may only back off while a result is blocked
	`ARXBSP_ASSERT(a_ready_free, clk, arst_n, !out_stall |-> in_ready, "block refused with output free")
	// reset clears the output asynchronously, so no result may show after a sampled reset
	`ARXBSP_ASSERT_ALWAYS(a_reset_empty, clk, !arst_n |=> !out_valid, "result valid after reset")

endmodule

bind arx_byte_shuffle_permutation arxbsp_checker u_arxbsp_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_ready  (block.ready),
	.out_valid (result.valid),
	.out_ready (result.ready),
	.out_data  (result.data)
);

`default_nettype wire

### test/arx_byte_shuffle_permutation_tb.sv
// Self-checking testbench for the ARX byte-shuffle permutation pipeline.
`default_nettype none

module arx_byte_shuffle_permutation_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import arxbsp_pkg::blk_t;
	import arxbsp_pkg::res_t;

	localparam int ROUNDS = arxbsp_pkg::NUM_ROUNDS_DEF;
	localparam int RANDOM_BLOCKS = 1750;
	localparam int CALM_TAIL = 150;
	localparam int MAX_REPORTS = 10;
	localparam int CYCLE_LIMIT = 200000;

	localparam int PERM_A [16] = '{0, 5, 10, 15, 4, 9, 14, 3, 8, 13, 2, 7, 12, 1, 6, 11};
	localparam int PERM_B [16] = '{1, 2, 3, 0, 6, 7, 4, 5, 10, 11, 8, 9, 15, 12, 13, 14};
	localparam int PERM_C [16] = '{2, 3, 0, 1, 6, 7, 4, 5, 10, 11, 8, 9, 14, 15, 12, 13};
	localparam int PERM_D [16] = '{3, 0, 1, 2, 7, 4, 5, 6, 11, 8, 9, 10, 15, 12, 13, 14};

	localparam string FIELD_NAMES [8] = '{"out_a_low", "out_a_high", "out_b_low", "out_b_high",
		"out_c_low", "out_c_high", "out_d_low", "out_d_high"};

	logic clk;
	logic arst_n = 1'b0;

	arxbsp_stream_if #(.T(blk_t)) blk_ch ();
	arxbsp_stream_if #(.T(res_t)) res_ch ();

	arx_byte_shuffle_permutation #(
		.NUM_ROUNDS(ROUNDS)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.block(blk_ch),
		.result(res_ch)
	);

	blk_t pending_blocks [$];
	res_t expected_states [$];
	int total_blocks;
	int accepted_blocks;
	int mismatches;
	int cycles;
	int src_gap;
	int sink_gap;
	res_t want;
	logic field_bad;

	always begin
		clk = 1'b0;
		#10;
		clk = 1'b1;
		#10;
	end

	function automatic logic [127:0] shuffle_bytes(input logic [127:0] w, input int lst [16]);
		logic [127:0] r;
		for (int i = 0; i < 16; i++) begin
			r[8*i +: 8] = w[8*lst[15-i] +: 8];
		end
		return r;
	endfunction

	function automatic void mix_words(inout logic [127:0] a, inout logic [127:0] b,
		inout logic [127:0] c, inout logic [127:0] d);
		a = a ^ b;
		c = c ^ d;
		b = b ^ c;
		d = d ^ a ^ b;
		// wrap each 64-bit half on its own
		a[63:0] = a[63:0] + b[63:0];
		a[127:64] = a[127:64] + b[127:64];
	endfunction

	function automatic res_t permute_block(input blk_t in);
		logic [127:0] a, b, c, d;
		logic [63:0] rc;
		res_t r;
		a = {in.a_high, in.a_low};
		b = {in.b_high, in.b_low};
		c = {in.c_high, in.c_low};
		d = {in.d_high, in.d_low};
		for (int rnd = 0; rnd < ROUNDS; rnd++) begin
			rc = (rnd < 32) ? (64'd1 << rnd) : 64'd0;
			a = a ^ {rc, rc};
			mix_words(a, b, c, d);
			a = shuffle_bytes(a, PERM_A);
			mix_words(a, b, c, d);
			b = shuffle_bytes(b, PERM_B);
			c = shuffle_bytes(c, PERM_C);
			d = shuffle_bytes(d, PERM_D);
		end
		r.out_a_low = a[63:0];
		r.out_a_high = a[127:64];
		r.out_b_low = b[63:0];
		r.out_b_high = b[127:64];
		r.out_c_low = c[63:0];
		r.out_c_high = c[127:64];
		r.out_d_low = d[63:0];
		r.out_d_high = d[127:64];
		return r;
	endfunction

	function automatic logic [63:0] rand_half(input int kind);
		logic [63:0] v;
		v = {$urandom, $urandom};
		case (kind)
			1: begin
				v = v & {$urandom, $urandom} & {$urandom, $urandom};
			end
			2: begin
				v = v | {$urandom, $urandom} | {$urandom, $urandom};
			end
			3: begin
				case ($urandom_range(0, 2))
					0: v = '0;
					1: v = '1;
					default: ;
				endcase
			end
			default: ;
		endcase
		return v;
	endfunction

	// Driver: present queued blocks, with random idle bursts until the tail.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			blk_ch.valid <= 1'b0;
			blk_ch.data <= '0;
			src_gap = 0;
		end else begin
			if (blk_ch.valid && blk_ch.ready) begin
				expected_states.push_back(permute_block(blk_ch.data));
				accepted_blocks++;
			end
			if (!blk_ch.valid || blk_ch.ready) begin
				if (src_gap > 0) begin
					src_gap--;
					blk_ch.valid <= 1'b0;
				end else if (pending_blocks.size() > CALM_TAIL && $urandom_range(0, 7) == 0) begin
					src_gap = $urandom_range(0, 3);
					blk_ch.valid <= 1'b0;
				end else if (pending_blocks.size() > 0) begin
					blk_ch.valid <= 1'b1;
					blk_ch.data <= pending_blocks.pop_front();
				end else begin
					blk_ch.valid <= 1'b0;
				end
			end
		end
	end

	// Monitor: check each result transaction against the oldest prediction.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_ch.ready <= 1'b0;
			sink_gap = 0;
		end else begin
			if (res_ch.valid && res_ch.ready) begin
				if (expected_states.size() == 0) begin
					mismatches++;
					if (mismatches <= MAX_REPORTS)
						$display("unexpected result transaction %h", res_ch.data);
				end else begin
					want = expected_states.pop_front();
					for (int k = 0; k < 8; k++) begin
						field_bad = want[64*(7-k) +: 64] !== res_ch.data[64*(7-k) +: 64];
						if (field_bad) begin
							mismatches++;
							if (mismatches <= MAX_REPORTS)
								$display("%s mismatch: expected %h, actual %h", FIELD_NAMES[k],
									want[64*(7-k) +: 64], res_ch.data[64*(7-k) +: 64]);
						end
					end
				end
			end
			if (sink_gap > 0) begin
				sink_gap--;
				res_ch.ready <= 1'b0;
			end else if (pending_blocks.size() > CALM_TAIL && $urandom_range(0, 7) == 0) begin
				sink_gap = $urandom_range(0, 3);
				res_ch.ready <= 1'b0;
			end else begin
				res_ch.ready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles >= CYCLE_LIMIT) begin
			$display("CHECK FAILED");
			$finish;
		end
	end

	initial begin
		blk_t blk;
		int kind;
		blk_ch.valid = 1'b0;
		blk_ch.data = '0;
		res_ch.ready = 1'b0;

		// extremes of the whole state
		pending_blocks.push_back('0);
		pending_blocks.push_back('1);
		// one field at all ones, then one field at one
		for (int k = 0; k < 8; k++) begin
			blk = '0;
			blk[64*(7-k) +: 64] = '1;
			pending_blocks.push_back(blk);
		end
		for (int k = 0; k < 8; k++) begin
			blk = '0;
			blk[64*(7-k) +: 64] = 64'd1;
			pending_blocks.push_back(blk);
		end
		pending_blocks.push_back({8{64'h5555_5555_5555_5555}});
		pending_blocks.push_back({8{64'haaaa_aaaa_aaaa_aaaa}});
		pending_blocks.push_back({8{64'h8000_0000_0000_0000}});
		// carry runs through the whole of each half of a
		blk = '0;
		blk.a_low = '1;
		blk.a_high = '1;
		blk.b_low = 64'd1;
		blk.b_high = 64'd1;
		pending_blocks.push_back(blk);

		for (int n = 0; n < RANDOM_BLOCKS; n++) begin
			kind = $urandom_range(0, 5);
			for (int k = 0; k < 8; k++)
				blk[64*k +: 64] = rand_half(kind > 3 ? 0 : kind);
			pending_blocks.push_back(blk);
		end
		total_blocks = pending_blocks.size();

		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		while (accepted_blocks < total_blocks || expected_states.size() != 0)
			@(posedge clk);
		// drain: nothing more may come out of the pipeline
		repeat (2 * ROUNDS + 8) @(posedge clk);
		if (mismatches == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end
endmodule

`default_nettype wire
